/* src/tgc_pkg.sv */
// shared constants, types and store request bundle for the triangle counter
// no dependencies; used by every module of the block by scoped names
package tgc_pkg;

  // largest graph the stores hold
  localparam int MAX_NODES = 64;

  // derived widths
  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int TRACE_W = $clog2(MAX_NODES * MAX_NODES * MAX_NODES + 1);

  // popcount split into byte-sized chunks
  localparam int CHUNK_W = 8;
  localparam int CHUNKS = (MAX_NODES + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W = CHUNKS * CHUNK_W;
  localparam int CHUNK_CNT_W = $clog2(CHUNK_W + 1);

  // divide by six as a multiply by a rounded-up reciprocal and a shift
  localparam int DIVISOR = 6;
  localparam int DIV_SHIFT = TRACE_W + 3;
  localparam int RECIP_W = TRACE_W + 1;
  localparam longint DIV_RECIP = ((longint'(1) << DIV_SHIFT) + DIVISOR - 1) / DIVISOR;

  // port field widths
  localparam int NODE_W = 7;
  localparam int FIELD_IDX_W = 6;
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [NODE_W-1:0] NODE_COUNT_RESET = 7'd64;

  // configuration port
  localparam int ADDR_W = 2;
  localparam int DATA_W = 32;
  localparam int REG_NODE_COUNT = 0;

  typedef logic [MAX_NODES-1:0] word_t;

  // one cycle of accesses to a bit store
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    word_t            wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic             clear;
  } store_req_t;

endpackage

/* src/tgc_store.sv */
// adjacency bit store: one word per node, registered read, per-word valid bits
// depends on tgc_pkg; a word never written since the last clear reads as zero
module tgc_store (
  input  logic                clk,
  input  logic                rst,
  input  tgc_pkg::store_req_t req,
  output tgc_pkg::word_t      rd_word
);

  localparam int MAX_NODES = tgc_pkg::MAX_NODES;

  tgc_pkg::word_t         mem [MAX_NODES];
  tgc_pkg::word_t         rd_data;
  logic [MAX_NODES-1:0]   valid;
  logic                   rd_ok;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

  // valid bits, cleared at once on reset or after a count
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      rd_ok <= valid[req.rd_addr];
    end
  end

  // unwritten words read as zero
  assign rd_word = rd_ok ? rd_data : '0;

endmodule

/* src/tgc_tally.sv */
// shared popcount and accumulate unit: counts ones of row AND column words
// depends on tgc_pkg; three register stages from word in to running sum
module tgc_tally (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           clear,
  input  logic                           take,
  input  tgc_pkg::word_t                 row_word,
  input  tgc_pkg::word_t                 col_word,
  output logic [tgc_pkg::TRACE_W-1:0]    acc
);

  localparam int CHUNKS = tgc_pkg::CHUNKS;
  localparam int CHUNK_W = tgc_pkg::CHUNK_W;
  localparam int PAD_W = tgc_pkg::PAD_W;
  localparam int CHUNK_CNT_W = tgc_pkg::CHUNK_CNT_W;
  localparam int CNT_W = tgc_pkg::CNT_W;
  localparam int TRACE_W = tgc_pkg::TRACE_W;

  logic [PAD_W-1:0]       both;
  logic [CHUNK_CNT_W-1:0] chunk_cnt [CHUNKS];
  logic [CHUNK_CNT_W-1:0] p1_cnt [CHUNKS];
  logic                   p1_valid;
  logic [CNT_W-1:0]       chunk_sum;
  logic [CNT_W-1:0]       p2_sum;
  logic                   p2_valid;

  // per-byte ones count
  always_comb begin
    both = PAD_W'(row_word & col_word);
    for (int k = 0; k < CHUNKS; k++) begin
      chunk_cnt[k] = '0;
      for (int b = 0; b < CHUNK_W; b++) begin
        chunk_cnt[k] = chunk_cnt[k] + CHUNK_CNT_W'(both[k*CHUNK_W + b]);
      end
    end
  end

  // sum of the byte counts
  always_comb begin
    chunk_sum = '0;
    for (int k = 0; k < CHUNKS; k++) begin
      chunk_sum = chunk_sum + CNT_W'(p1_cnt[k]);
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    p1_cnt <= chunk_cnt;
    p2_sum <= chunk_sum;
  end

  // valid chain and running sum
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      acc      <= '0;
    end else begin
      p1_valid <= take;
      p2_valid <= p1_valid;
      if (p2_valid) begin
        acc <= acc + TRACE_W'(p2_sum);
      end
    end
  end

endmodule

/* src/tgc_div6.sv */
// reciprocal-multiply divider by six with saturation to the result width
// depends on tgc_pkg; product registered on start, done pulses in the following cycle
module tgc_div6 (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tgc_pkg::TRACE_W-1:0]    dividend,
  output logic                           done,
  output logic [tgc_pkg::COUNT_W-1:0]    quotient
);

  localparam int TRACE_W = tgc_pkg::TRACE_W;
  localparam int RECIP_W = tgc_pkg::RECIP_W;
  localparam int PROD_W = TRACE_W + RECIP_W;
  localparam int DIV_SHIFT = tgc_pkg::DIV_SHIFT;
  localparam int COUNT_W = tgc_pkg::COUNT_W;

  logic [PROD_W-1:0]  prod;
  logic [TRACE_W-1:0] quo;

  // x/6 as x*ceil(2^s/6) >> s, exact over the whole dividend range
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
    if (start) begin
      prod <= PROD_W'(dividend) * PROD_W'(tgc_pkg::DIV_RECIP);
    end
  end

  assign quo = TRACE_W'(prod >> DIV_SHIFT);

  // saturate to the output width
  assign quotient = (32'(quo) > 32'(tgc_pkg::COUNT_MAX)) ? tgc_pkg::COUNT_MAX
                                                         : COUNT_W'(quo);

endmodule

/* src/graph_triangle_counter_top.sv */
// triangle counter: a loaded entry is a store read, then a write back; after the
// last entry comes a count over n active nodes (per row a fetch and a latch, then
// one row word read a cycle through the shared popcount unit), a drain, a divide
// and a result, plus any wait for the previous count; in_ready is low meanwhile
// synchronous reset: node_count returns to 64, both stores read as zero at once
// through their valid bits (no clearing pass), the result register empties
module graph_triangle_counter_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tgc_pkg::ADDR_W-1:0]         paddr,
  input  logic [tgc_pkg::DATA_W-1:0]         pwdata,
  output logic [tgc_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tgc_pkg::FIELD_IDX_W-1:0]    row_index,
  input  logic [tgc_pkg::FIELD_IDX_W-1:0]    col_index,
  input  logic                               edge_bit,
  input  logic                               last_entry,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tgc_pkg::COUNT_W-1:0]        triangle_count
);

  localparam int MAX_NODES = tgc_pkg::MAX_NODES;
  localparam int IDX_W = tgc_pkg::IDX_W;
  localparam int CNT_W = tgc_pkg::CNT_W;
  localparam int NODE_W = tgc_pkg::NODE_W;
  localparam int DATA_W = tgc_pkg::DATA_W;
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_FETCH,
    S_LATCH,
    S_SCAN,
    S_DRAIN,
    S_DIV_GO,
    S_DIV_WAIT,
    S_EMIT
  } state_t;

  state_t                       state;
  logic [NODE_W-1:0]            node_count;
  logic [CNT_W-1:0]             act_n;
  tgc_pkg::word_t               mask;
  logic                         in_hit;
  logic                         reg_hit;

  logic [IDX_W-1:0]             ld_row;
  logic [IDX_W-1:0]             ld_col;
  logic                         ld_edge;
  logic                         ld_last;
  logic                         ld_hit;

  logic [IDX_W-1:0]             i_idx;
  logic [IDX_W-1:0]             j_idx;
  logic                         last_i;
  logic                         last_j;
  tgc_pkg::word_t               row_i;
  tgc_pkg::word_t               col_i;
  logic [1:0]                   drain_cnt;
  logic                         take;

  tgc_pkg::store_req_t          row_req;
  tgc_pkg::store_req_t          col_req;
  tgc_pkg::word_t               row_word;
  tgc_pkg::word_t               col_word;
  tgc_pkg::word_t               row_new;
  tgc_pkg::word_t               col_new;

  logic                         tally_clear;
  logic [tgc_pkg::TRACE_W-1:0]  trace_sum;
  logic                         div_start;
  logic                         div_done;
  logic [tgc_pkg::COUNT_W-1:0]  div_q;
  logic                         emit_fire;

  // configuration register
  assign pready  = 1'b1;
  assign reg_hit = (32'(paddr) >> 2) == 32'(tgc_pkg::REG_NODE_COUNT);
  assign prdata  = reg_hit ? DATA_W'(node_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= tgc_pkg::NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      node_count <= pwdata[NODE_W-1:0];
    end
  end

  // active node count, range check and column mask
  always_comb begin
    act_n  = (32'(node_count) > 32'(MAX_NODES)) ? CNT_W'(MAX_NODES) : CNT_W'(node_count);
    in_hit = (32'(row_index) < 32'(act_n)) && (32'(col_index) < 32'(act_n));
    for (int k = 0; k < MAX_NODES; k++) begin
      mask[k] = 32'(k) < 32'(act_n);
    end
  end

  assign last_i = (CNT_W'(i_idx) + CNT_W'(1)) == act_n;
  assign last_j = (CNT_W'(j_idx) + CNT_W'(1)) == act_n;

  // read-modify-write of one bit in each store
  always_comb begin
    row_new         = row_word;
    row_new[ld_col] = ld_edge;
    col_new         = col_word;
    col_new[ld_row] = ld_edge;
  end

  assign emit_fire   = (state == S_EMIT) && (!out_valid || out_ready);
  assign tally_clear = (state == S_LOAD) && ld_last;
  assign div_start   = (state == S_DIV_GO);
  assign in_ready    = (state == S_IDLE);

  // store access requests
  always_comb begin
    row_req.wr_en   = (state == S_LOAD) && ld_hit;
    row_req.wr_addr = ld_row;
    row_req.wr_data = row_new;
    row_req.clear   = emit_fire;
    case (state)
      S_IDLE:  row_req.rd_addr = IDX_W'(row_index);
      S_FETCH: row_req.rd_addr = i_idx;
      default: row_req.rd_addr = j_idx;
    endcase

    col_req.wr_en   = (state == S_LOAD) && ld_hit;
    col_req.wr_addr = ld_col;
    col_req.wr_data = col_new;
    col_req.clear   = emit_fire;
    case (state)
      S_IDLE:  col_req.rd_addr = IDX_W'(col_index);
      default: col_req.rd_addr = i_idx;
    endcase
  end

  tgc_store u_row_store (
    .clk     (clk),
    .rst     (rst),
    .req     (row_req),
    .rd_word (row_word)
  );

  tgc_store u_col_store (
    .clk     (clk),
    .rst     (rst),
    .req     (col_req),
    .rd_word (col_word)
  );

  tgc_tally u_tally (
    .clk      (clk),
    .rst      (rst),
    .clear    (tally_clear),
    .take     (take),
    .row_word (row_word),
    .col_word (col_i),
    .acc      (trace_sum)
  );

  tgc_div6 u_div6 (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (trace_sum),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      take      <= 1'b0;
      drain_cnt <= '0;
    end else begin
      take <= (state == S_SCAN) && row_i[j_idx];
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ld_row  <= IDX_W'(row_index);
            ld_col  <= IDX_W'(col_index);
            ld_edge <= edge_bit;
            ld_last <= last_entry;
            ld_hit  <= in_hit;
            state   <= S_LOAD;
          end
        end
        S_LOAD: begin
          i_idx <= '0;
          if (!ld_last) begin
            state <= S_IDLE;
          end else if (act_n == '0) begin
            state <= S_DIV_GO;
          end else begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_LATCH;
        end
        S_LATCH: begin
          row_i <= row_word;
          col_i <= col_word & mask;
          j_idx <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          j_idx <= j_idx + IDX_W'(1);
          if (last_j) begin
            if (last_i) begin
              drain_cnt <= '0;
              state     <= S_DRAIN;
            end else begin
              i_idx <= i_idx + IDX_W'(1);
              state <= S_FETCH;
            end
          end
        end
        S_DRAIN: begin
          drain_cnt <= drain_cnt + 2'd1;
          if (drain_cnt == DRAIN_LAST) begin
            state <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            triangle_count <= div_q;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
